[rtl/mvtnm_pkg.sv]
// Shared types, constants and tables of the tone and noise mixer.
package mvtnm_pkg;

    localparam int VOICES_DEFAULT = 48;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_VOLUME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED       = 2'd1;

    localparam logic [6:0] MASTER_VOLUME_RESET = 7'd80;

    localparam logic [2:0] SHAPE_SQUARE   = 3'd0;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
    localparam logic [2:0] SHAPE_NOISE    = 3'd2;
    localparam logic [2:0] SHAPE_SAW      = 3'd3;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // step*44100 > 2000*2^24 holds exactly for step above this value
    localparam logic [22:0] NOISE_STEP_LIMIT = 23'd760871;
    // 2^18/5 rounded up; exact for products below 2^18
    localparam logic [15:0] RECIP_FIVE = 16'd52429;

    // Output scale 1/(65536*200) = shift by 19, then divide by 25.
    // Clamp the shifted product here: the quotient then saturates either sign
    localparam logic [19:0] OUT_CLAMP = 20'd819225;
    // 2^25/25 rounded up; exact for inputs below 2^20
    localparam logic [20:0] RECIP_25  = 21'd1342178;

    localparam int DIV_DEN_W   = 24;

    typedef struct packed {
        logic [2:0]  shape;
        logic [23:0] phase;
        logic [22:0] step;
        logic [22:0] end_step;
        logic [15:0] elapsed;
        logic [15:0] length;
        logic [15:0] gain;
    } voice_t;

    localparam int VOICE_W = $bits(voice_t);

    // Quarter-wave sine in Q16 at k*pi/32
    function automatic logic [16:0] sine_quarter(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd6424;
            5'd2:  v = 17'd12785;
            5'd3:  v = 17'd19024;
            5'd4:  v = 17'd25080;
            5'd5:  v = 17'd30893;
            5'd6:  v = 17'd36410;
            5'd7:  v = 17'd41576;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd50660;
            5'd10: v = 17'd54491;
            5'd11: v = 17'd57798;
            5'd12: v = 17'd60547;
            5'd13: v = 17'd62714;
            5'd14: v = 17'd64277;
            5'd15: v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

[rtl/mvtnm_ram.sv]
// Generic single-port-write, registered-read RAM.
module mvtnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mvtnm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module mvtnm_div #(
    parameter int NW   = 48,
    parameter int DW   = 24,
    parameter int CNTW = $clog2(NW + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   num,
    input  logic [DW-1:0]   den,
    input  logic [CNTW-1:0] bits,
    output logic            busy,
    output logic [NW-1:0]   quot
);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   acc_reg, acc_next;
    logic [DW-1:0]   den_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {rem_reg, acc_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bits;
            rem_next  = '0;
            acc_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            acc_next = {acc_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quot = acc_reg;

endmodule

[rtl/multi_voice_tone_noise_mixer.sv]
// Top level of the multi-voice tone and noise mixer.
//
// Input channel (in_valid/in_ready) carries one item: mode 0 starts a voice
// with the given shape, steps, duration and volume; mode 1 ticks one frame.
// Each tick yields one item on the output channel (out_valid/out_ready),
// the saturated mixed sample used for both stereo channels. Starts yield none.
// Configuration writes (cfg_valid/cfg_ready) are always taken: index 0 is the
// master volume in percent, index 1 the enable.
// Voice state lives in one RAM, one entry per voice; active flags are flops.
// A start scans the active flags one per cycle.
// A tick while disabled yields a zero sample. An enabled tick scans every voice;
// each active voice waits on the shared serial divider (32-bit envelope
// quotient, then 23-bit slide quotient); after the scan the block scales,
// saturates and presents the sample.
// Reset clears all active flags, sets master volume 80, disables the block
// and seeds the noise generator with one; the RAM is not cleared.
// A finished sample waits in the output register; the block keeps taking
// start items meanwhile, and a further tick holds its result until the
// output register is free.
module multi_voice_tone_noise_mixer #(
    parameter int VOICES = mvtnm_pkg::VOICES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [2:0]                         wave_shape,
    input  logic [22:0]                        start_step,
    input  logic [22:0]                        end_step,
    input  logic [15:0]                        duration,
    input  logic [15:0]                        volume,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [15:0]                 sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mvtnm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mvtnm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW   = $clog2(VOICES + 1);
    localparam int SW   = 19 + $clog2(VOICES);
    localparam int NW   = SW + 22;
    localparam int DW   = mvtnm_pkg::DIV_DEN_W;
    localparam int CNTW = $clog2(NW + 1);

    localparam logic [CNTW-1:0] ENV_BITS  = CNTW'(32);
    localparam logic [CNTW-1:0] DIFF_BITS = CNTW'(23);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_TSCAN = 4'd2;
    localparam logic [3:0] S_CAP   = 4'd3;
    localparam logic [3:0] S_WAVE  = 4'd4;
    localparam logic [3:0] S_WAVE2 = 4'd5;
    localparam logic [3:0] S_ENVW  = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_DIFW  = 4'd10;
    localparam logic [3:0] S_WB    = 4'd11;
    localparam logic [3:0] S_OMUL  = 4'd12;
    localparam logic [3:0] S_ODIV  = 4'd13;
    localparam logic [3:0] S_OSAT  = 4'd14;
    localparam logic [3:0] S_HOLD  = 4'd15;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [VOICES-1:0] active_reg, active_next;
    logic [6:0]        master_volume_reg, master_volume_next;
    logic              enabled_reg, enabled_next;
    logic [31:0]       seed_reg, seed_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [2:0]               in_shape_reg;
    logic [22:0]              in_start_reg;
    logic [22:0]              in_end_reg;
    logic [15:0]              in_len_reg;
    logic [15:0]              in_gain_reg;
    mvtnm_pkg::voice_t        v_reg;
    logic [30:0]              sin_prod_reg;
    logic [16:0]              sin_lo_reg;
    logic                     sin_sat_reg;
    logic                     sin_neg_reg;
    logic signed [17:0]       wave_reg, wave_next;
    logic [15:0]              env_reg;
    logic signed [34:0]       m1_reg;
    logic signed [35:0]       m2_reg;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic [NW-1:0]            oprod_reg;
    logic [40:0]              oq_prod_reg;
    logic                     oneg_reg;
    logic                     diff_neg_reg;
    logic signed [15:0]       hold_reg, hold_next;
    logic signed [15:0]       sample_reg;

    // RAM and divider hookup
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    mvtnm_pkg::voice_t        ram_wdata;
    mvtnm_pkg::voice_t        ram_rdata;
    logic [mvtnm_pkg::VOICE_W-1:0] ram_rbits;
    logic                     div_start;
    logic [NW-1:0]            div_num;
    logic [DW-1:0]            div_den;
    logic [CNTW-1:0]          div_bits;
    logic                     div_busy;
    logic [NW-1:0]            div_quot;

    logic in_fire;
    logic [AW-1:0] k_idx;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign k_idx     = k_reg[AW-1:0];
    assign ram_rdata = mvtnm_pkg::voice_t'(ram_rbits);

    mvtnm_ram #(
        .WIDTH (mvtnm_pkg::VOICE_W),
        .DEPTH (VOICES),
        .AW    (AW)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (k_idx),
        .rdata (ram_rbits)
    );

    mvtnm_div #(
        .NW   (NW),
        .DW   (DW),
        .CNTW (CNTW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .bits  (div_bits),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Sine quarter-wave lookup from the captured phase
    logic [1:0]  quad;
    logic [22:0] xq;
    logic [4:0]  sidx;
    logic [16:0] s_lo, s_hi;
    logic [30:0] s_prod;
    assign quad   = v_reg.phase[23:22];
    assign xq     = quad[0] ? (23'h400000 - {1'b0, v_reg.phase[21:0]})
                            : {1'b0, v_reg.phase[21:0]};
    assign sidx   = xq[22:18];
    assign s_lo   = mvtnm_pkg::sine_quarter(sidx);
    assign s_hi   = mvtnm_pkg::sine_quarter(sidx + 5'd1);
    assign s_prod = 31'(s_hi - s_lo) * 31'(xq[17:0]);

    // Envelope numerator
    logic [19:0] el10;
    logic [31:0] env_num;
    assign el10    = {v_reg.elapsed, 4'b0} - {3'b0, v_reg.elapsed, 1'b0}
                     - {2'b0, v_reg.elapsed, 2'b0};
    assign env_num = (el10 < {4'b0, v_reg.length})
                     ? {el10[15:0], 16'b0}
                     : {v_reg.length - v_reg.elapsed, 16'b0};

    // Slide difference
    logic signed [23:0] sdiff;
    logic [22:0]        sdiff_mag;
    assign sdiff     = $signed({1'b0, v_reg.end_step}) - $signed({1'b0, v_reg.step});
    assign sdiff_mag = sdiff[23] ? 23'(-sdiff) : sdiff[22:0];

    // Wave formation from registered partials
    logic signed [17:0] noise_raw;
    logic [16:0]        noise_mag;
    logic [18:0]        noise_t;
    logic [34:0]        noise_q;
    logic [16:0]        sine_mag;
    assign noise_raw = $signed({1'b0, seed_reg[23:8], 1'b0}) - 18'sd65536;
    assign noise_mag = noise_raw[17] ? 17'(-noise_raw) : noise_raw[16:0];
    assign noise_t   = {1'b0, noise_mag, 1'b0} + {2'b0, noise_mag};
    assign noise_q   = 35'(noise_t) * 35'(mvtnm_pkg::RECIP_FIVE);
    assign sine_mag  = sin_sat_reg ? 17'd65536 : sin_lo_reg + 17'(sin_prod_reg[30:18]);

    always_comb
    begin
        case (v_reg.shape)
            mvtnm_pkg::SHAPE_SQUARE:
                wave_next = v_reg.phase[23] ? -18'sd65536 : 18'sd65536;
            mvtnm_pkg::SHAPE_TRIANGLE:
                wave_next = v_reg.phase[23]
                            ? 18'(19'sd196608 - $signed({1'b0, v_reg.phase[23:6]}))
                            : 18'($signed({1'b0, v_reg.phase[23:6]}) - 19'sd65536);
            mvtnm_pkg::SHAPE_NOISE:
                if (v_reg.step > mvtnm_pkg::NOISE_STEP_LIMIT)
                begin
                    wave_next = noise_raw[17] ? -$signed({1'b0, noise_q[34:18]})
                                              : $signed({1'b0, noise_q[34:18]});
                end
                else
                begin
                    wave_next = noise_raw;
                end
            mvtnm_pkg::SHAPE_SAW:
                wave_next = 18'($signed({2'b0, v_reg.phase[23:7]}) - 19'sd65536);
            default:
                wave_next = sin_neg_reg ? -$signed({1'b0, sine_mag})
                                        : $signed({1'b0, sine_mag});
        endcase
    end

    // Truncate toward zero after the Q16 products
    logic signed [34:0] m1_adj;
    logic signed [18:0] v1;
    logic signed [35:0] m2_adj;
    logic signed [19:0] v2;
    assign m1_adj = m1_reg + $signed({19'd0, {16{m1_reg[34]}}});
    assign v1     = m1_adj[34:16];
    assign m2_adj = m2_reg + $signed({20'd0, {16{m2_reg[35]}}});
    assign v2     = m2_adj[35:16];

    // Output scaling: |sum| * master_volume * 32767
    logic [21:0]   mvk;
    logic [SW-1:0] sum_mag;
    assign mvk     = {master_volume_reg, 15'b0} - 22'(master_volume_reg);
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    // Divide the product by 2^19, clamp, then divide by 25 through a reciprocal
    logic [NW-20:0] oy_full;
    logic [19:0]    oy;
    logic [15:0]    oq;
    assign oy_full = oprod_reg[NW-1:19];
    assign oy      = (oy_full >= (NW-19)'(mvtnm_pkg::OUT_CLAMP)) ? mvtnm_pkg::OUT_CLAMP
                                                               : oy_full[19:0];
    assign oq      = oq_prod_reg[40:25];

    // Saturation of the scaled quotient
    always_comb
    begin
        if (oneg_reg)
        begin
            hold_next = (oq > 16'd32768) ? -16'sd32768 : $signed(16'd0 - oq);
        end
        else
        begin
            hold_next = (oq > 16'd32767) ? 16'sd32767 : $signed(oq);
        end
    end

    // Write-back values
    logic [22:0] step_wb;
    logic [15:0] el_wb;
    assign step_wb = diff_neg_reg ? (v_reg.step - div_quot[22:0])
                                  : (v_reg.step + div_quot[22:0]);
    assign el_wb   = v_reg.elapsed + 16'd1;

    always_comb
    begin
        state_next         = state_reg;
        k_next             = k_reg;
        active_next        = active_reg;
        master_volume_next = master_volume_reg;
        enabled_next       = enabled_reg;
        seed_next          = seed_reg;
        out_valid_next     = out_valid_reg;
        sum_next           = sum_reg;
        ram_we             = 1'b0;
        ram_waddr          = k_idx;
        ram_wdata          = v_reg;
        div_start          = 1'b0;
        div_num            = '0;
        div_den            = DW'(v_reg.length);
        div_bits           = ENV_BITS;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mvtnm_pkg::CFG_MASTER_VOLUME: master_volume_next = cfg_data;
                mvtnm_pkg::CFG_ENABLED:       enabled_next       = cfg_data[0];
                default: ;
            endcase
        end

        // drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (in_fire)
                begin
                    if (!mode)
                    begin
                        state_next = S_FIND;
                    end
                    else if (!enabled_reg)
                    begin
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        sum_next   = '0;
                        state_next = S_TSCAN;
                    end
                end
            end
            S_FIND:
            begin
                // claim the first idle voice, voice 0 when all are busy
                if (!active_reg[k_idx] || k_reg == CW'(VOICES - 1))
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = active_reg[k_idx] ? '0 : k_idx;
                    ram_wdata.shape   = in_shape_reg;
                    ram_wdata.phase   = '0;
                    ram_wdata.step    = in_start_reg;
                    ram_wdata.end_step = in_end_reg;
                    ram_wdata.elapsed = '0;
                    ram_wdata.length  = (in_len_reg == 16'd0) ? 16'd1 : in_len_reg;
                    ram_wdata.gain    = in_gain_reg;
                    active_next[ram_waddr] = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_TSCAN:
            begin
                if (k_reg == CW'(VOICES))
                begin
                    state_next = S_OMUL;
                end
                else if (active_reg[k_idx])
                begin
                    state_next = S_CAP;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_CAP:
            begin
                state_next = S_WAVE;
            end
            S_WAVE:
            begin
                if (v_reg.shape == mvtnm_pkg::SHAPE_NOISE)
                begin
                    seed_next = seed_reg * mvtnm_pkg::LCG_MUL + mvtnm_pkg::LCG_ADD;
                end
                div_start  = 1'b1;
                div_num    = {env_num, (NW-32)'(0)};
                div_den    = DW'(v_reg.length);
                div_bits   = ENV_BITS;
                state_next = S_WAVE2;
            end
            S_WAVE2:
            begin
                state_next = S_ENVW;
            end
            S_ENVW:
            begin
                if (!div_busy)
                begin
                    div_start  = 1'b1;
                    div_num    = {sdiff_mag, (NW-23)'(0)};
                    div_den    = DW'(v_reg.length);
                    div_bits   = DIFF_BITS;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next   = sum_reg + SW'(v2);
                state_next = S_DIFW;
            end
            S_DIFW:
            begin
                if (!div_busy)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // advance phase and slide, retire the voice at its end
                ram_we            = 1'b1;
                ram_wdata.phase   = v_reg.phase + 24'(v_reg.step);
                ram_wdata.step    = step_wb;
                ram_wdata.elapsed = el_wb;
                if (el_wb >= v_reg.length)
                begin
                    active_next[k_idx] = 1'b0;
                end
                k_next     = k_reg + 1'b1;
                state_next = S_TSCAN;
            end
            S_OMUL:
            begin
                state_next = S_ODIV;
            end
            S_ODIV:
            begin
                state_next = S_OSAT;
            end
            S_OSAT:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            k_reg             <= '0;
            active_reg        <= '0;
            master_volume_reg <= mvtnm_pkg::MASTER_VOLUME_RESET;
            enabled_reg       <= 1'b0;
            seed_reg          <= 32'd1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            k_reg             <= k_next;
            active_reg        <= active_next;
            master_volume_reg <= master_volume_next;
            enabled_reg       <= enabled_next;
            seed_reg          <= seed_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_shape_reg <= wave_shape;
            in_start_reg <= start_step;
            in_end_reg   <= end_step;
            in_len_reg   <= duration;
            in_gain_reg  <= volume;
        end
        if (state_reg == S_CAP)
        begin
            v_reg <= ram_rdata;
        end
        if (state_reg == S_WAVE)
        begin
            sin_prod_reg <= s_prod;
            sin_lo_reg   <= s_lo;
            sin_sat_reg  <= sidx[4];
            sin_neg_reg  <= quad[1];
        end
        if (state_reg == S_WAVE2)
        begin
            wave_reg <= wave_next;
        end
        if (state_reg == S_ENVW && !div_busy)
        begin
            env_reg      <= div_quot[15:0];
            diff_neg_reg <= sdiff[23];
        end
        if (state_reg == S_MUL1)
        begin
            m1_reg <= 35'(wave_reg) * $signed({19'd0, env_reg});
        end
        if (state_reg == S_MUL2)
        begin
            m2_reg <= 36'(v1) * $signed({20'd0, v_reg.gain});
        end
        if (state_reg == S_OMUL)
        begin
            oprod_reg <= NW'(sum_mag) * NW'(mvk);
            oneg_reg  <= sum_reg[SW-1];
        end
        if (state_reg == S_ODIV)
        begin
            oq_prod_reg <= 41'(oy) * 41'(mvtnm_pkg::RECIP_25);
        end
        sum_reg <= sum_next;
        if (state_reg == S_OSAT)
        begin
            hold_reg <= hold_next;
        end
        else if (state_reg == S_IDLE && in_fire && mode && !enabled_reg)
        begin
            hold_reg <= '0;
        end
        if (state_reg == S_HOLD && !out_valid_reg)
        begin
            sample_reg <= hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // The divider is never left running when the sequencer rests or writes back
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_wb_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> !div_busy)
        else $error("write-back before slide quotient is ready");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_HOLD))
        else $error("output item raised outside hold");

endmodule
